@@ rtl/tdpt_pkg.sv @@
// Shared types and constants for the trial division prime test block.
package tdpt_pkg;

  localparam int unsigned DIV_TWO    = 2;
  localparam int unsigned DIV_THREE  = 3;
  localparam int unsigned DIV_FIVE   = 5;
  localparam int unsigned DIV_SEVEN  = 7;
  localparam int unsigned DIV_ELEVEN = 11;
  localparam int unsigned DIV_STRIDE = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } tdpt_state_t;

  typedef struct packed {
    logic load;      // capture a new value and restart with divisor two
    logic step;      // one restoring division step
    logic next_div;  // advance the trial divisor and restart the division
  } tdpt_cmd_t;

  typedef struct packed {
    logic finish;    // the held value and the current division settle the answer
    logic prime;     // the answer, valid when finish is high
  } tdpt_status_t;

endpackage

@@ rtl/trial_division_prime_test.sv @@
// Top level of the trial division prime test: controller, datapath and result register.
//
//  Channel   Signals                      Beat width  Meaning
//  input     value, in_valid, in_stall    DATA_WIDTH  signed integer to test
//  output    is_prime, out_valid, out_stall  1        1 when the integer is prime
//
// Each trial divisor takes DATA_WIDTH steps of the restoring divider,
// followed by an evaluation of quotient and remainder.
// The largest 32-bit primes need about 23000 trial divisors.
// Reset is synchronous and active high; it returns the controller to idle,
// empties the result register and stalls the input while it is held.
// The input is stalled while an item is in work. A finished result waits in
// the result register; a new item may be accepted meanwhile, and its own
// answer is held back in evaluation until the register is free.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         is_prime,
  output logic                         out_valid,
  input  logic                         out_stall
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  logic         busy;
  logic         done;
  logic         out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy || rst;

  tdpt_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  tdpt_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .status (status)
  );

  // Result register: loads when the controller finishes, clears when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      is_prime <= status.prime;
    end
  end

endmodule

@@ rtl/tdpt_datapath.sv @@
// Datapath: held value, trial divisor and a one-bit-per-cycle restoring divider.
module tdpt_datapath import tdpt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] value,
  input  tdpt_cmd_t             cmd,
  output tdpt_status_t          status
);

  logic [DATA_WIDTH-1:0] held_value;
  logic [DATA_WIDTH-1:0] trial_divisor;
  logic [DATA_WIDTH-1:0] partial_remainder;
  logic [DATA_WIDTH-1:0] quotient;

  logic [DATA_WIDTH:0]   trial;
  logic                  fits;
  logic [DATA_WIDTH-1:0] divisor_next;
  logic                  trivial;
  logic                  rem_zero;
  logic                  small_div;
  logic                  loop_div;
  logic                  past_root;

  // Shift the next dividend bit into the remainder and subtract if it fits.
  assign trial = {partial_remainder, quotient[DATA_WIDTH-1]};
  assign fits  = trial >= {1'b0, trial_divisor};

  always_comb begin
    case (trial_divisor)
      DATA_WIDTH'(DIV_TWO):   divisor_next = DATA_WIDTH'(DIV_THREE);
      DATA_WIDTH'(DIV_THREE): divisor_next = DATA_WIDTH'(DIV_FIVE);
      DATA_WIDTH'(DIV_FIVE):  divisor_next = DATA_WIDTH'(DIV_SEVEN);
      DATA_WIDTH'(DIV_SEVEN): divisor_next = DATA_WIDTH'(DIV_ELEVEN);
      default:                divisor_next = trial_divisor + DATA_WIDTH'(DIV_STRIDE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value        <= '0;
      trial_divisor     <= '0;
      partial_remainder <= '0;
      quotient          <= '0;
    end else if (cmd.load) begin
      held_value        <= value;
      trial_divisor     <= DATA_WIDTH'(DIV_TWO);
      partial_remainder <= '0;
      quotient          <= value;
    end else if (cmd.step) begin
      partial_remainder <= fits ? DATA_WIDTH'(trial - {1'b0, trial_divisor})
                                : trial[DATA_WIDTH-1:0];
      quotient          <= {quotient[DATA_WIDTH-2:0], fits};
    end else if (cmd.next_div) begin
      trial_divisor     <= divisor_next;
      partial_remainder <= '0;
      quotient          <= held_value;
    end
  end

  // After a full division, quotient holds n / d and partial_remainder n % d.
  assign trivial   = held_value[DATA_WIDTH-1] || (held_value <= DATA_WIDTH'(1));
  assign rem_zero  = partial_remainder == '0;
  assign small_div = trial_divisor <= DATA_WIDTH'(DIV_ELEVEN);
  assign loop_div  = trial_divisor >= DATA_WIDTH'(DIV_ELEVEN);
  assign past_root = loop_div && (trial_divisor > quotient);

  always_comb begin
    status.finish = trivial || rem_zero || past_root;
    if (trivial) begin
      status.prime = 1'b0;
    end else if (small_div && rem_zero) begin
      status.prime = held_value == trial_divisor;
    end else if (past_root) begin
      status.prime = 1'b1;
    end else begin
      status.prime = 1'b0;
    end
  end

endmodule

@@ rtl/tdpt_ctrl.sv @@
// Controller: sequences the divisions and decides when an answer is ready.
module tdpt_ctrl import tdpt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         out_free,
  input  tdpt_status_t status,
  output tdpt_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  tdpt_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_step;

  assign last_step = cnt == CNT_W'(DATA_WIDTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    done       = 1'b0;
    busy       = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + CNT_W'(1);
        if (last_step) begin
          cnt_next   = '0;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!status.finish) begin
          cmd.next_div = 1'b1;
          cnt_next     = '0;
          state_next   = ST_DIV;
        end else if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !last_step) |=> state == ST_DIV)
    else $error("division left early");

  a_div_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && last_step) |=> (state == ST_EVAL && cnt == '0))
    else $error("division did not end in evaluation");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == ST_IDLE)
    else $error("answer given without returning to idle");

  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DIV && cnt == '0))
    else $error("new value did not start a division");

endmodule
